@@ hdl/bms_pkg.sv @@
// Package for the buzzer melody sequencer.
// Beat types, event codes, state record and reset constants; no dependencies.
package bms_pkg;

  localparam logic [3:0] FUNC_TICK       = 4'd0;
  localparam logic [3:0] FUNC_PLAY_PAUSE = 4'd1;
  localparam logic [3:0] FUNC_SPEED      = 4'd2;
  localparam logic [3:0] FUNC_NEXT       = 4'd3;
  localparam logic [3:0] FUNC_PREV       = 4'd4;
  localparam logic [3:0] FUNC_TONE_OVF   = 4'd5;
  localparam logic [3:0] FUNC_LOAD_NOTE  = 4'd6;
  localparam logic [3:0] FUNC_LOAD_START = 4'd7;
  localparam logic [3:0] FUNC_LOAD_FREQ  = 4'd8;

  localparam logic [1:0] CFG_BASE_SPEED = 2'd0;
  localparam logic [1:0] CFG_SONG_GAP   = 2'd1;

  localparam logic [9:0] BASE_SPEED_RST = 10'd500;
  localparam logic [9:0] SONG_GAP_RST   = 10'd1000;

  localparam logic [7:0]  END_MARK       = 8'hFF;
  localparam logic [15:0] STOP_LEAD_NORM = 16'd5;
  localparam logic [15:0] STOP_LEAD_FAST = 16'd2;

  typedef struct packed {
    logic [3:0]  func;
    logic [9:0]  addr;
    logic [15:0] data;
  } in_beat_t;

  typedef struct packed {
    logic        tone_on;
    logic        buzzer;
    logic [15:0] reload_value;
    logic [2:0]  song_number;
    logic        is_playing;
    logic        double_speed;
  } out_beat_t;

  typedef struct packed {
    logic        playing;
    logic        fast_mode;
    logic [2:0]  song_sel;
    logic [9:0]  note_pointer;
    logic [15:0] note_countdown;
    logic [9:0]  gap_countdown;
    logic [7:0]  freq_index;
    logic        tone_running;
    logic        pin_level;
  } play_state_t;

  typedef struct packed {
    logic note_we;
    logic start_we;
    logic freq_we;
  } mem_wr_t;

  localparam play_state_t STATE_RST = '{
    playing:        1'b0,
    fast_mode:      1'b0,
    song_sel:       3'd0,
    note_pointer:   10'd0,
    note_countdown: 16'd0,
    gap_countdown:  10'd0,
    freq_index:     8'd0,
    tone_running:   1'b0,
    pin_level:      1'b1
  };

endpackage

@@ hdl/bms_step.sv @@
// Next-state logic for one event of the melody sequencer.
// Uses bms_pkg; note bytes and reload value come prefetched from the top level.
module bms_step
  import bms_pkg::*;
#(
  parameter int SONG_COUNT     = 8,
  parameter int NOTE_MEM_DEPTH = 1024,
  parameter int FREQ_ENTRIES   = 256
) (
  input  play_state_t st,
  input  in_beat_t    beat,
  input  logic [9:0]  base_speed,
  input  logic [9:0]  song_gap,
  input  logic [7:0]  note0,
  input  logic [7:0]  note1,
  input  logic [15:0] reload_cur,
  output play_state_t st_nxt,
  output mem_wr_t     wr
);

  localparam logic [10:0] NOTE_LIM = 11'(NOTE_MEM_DEPTH);
  localparam logic [10:0] SONG_LIM = 11'(SONG_COUNT);
  localparam logic [10:0] FREQ_LIM = 11'(FREQ_ENTRIES);
  localparam logic [3:0]  SEL_LIM  = 4'(SONG_COUNT);
  localparam logic [2:0]  SEL_LAST = 3'(SONG_COUNT - 1);

  logic [3:0]  sel_sum;
  logic [2:0]  sel_inc;
  logic [2:0]  sel_dec;
  logic [7:0]  unit_ms;
  logic [15:0] note_len;
  logic [15:0] cd;
  logic [16:0] cd_dbl;
  logic        gap_busy;

  assign sel_sum  = {1'b0, st.song_sel} + 4'd1;
  assign sel_inc  = (sel_sum >= SEL_LIM) ? 3'd0 : sel_sum[2:0];
  assign sel_dec  = (st.song_sel == 3'd0) ? SEL_LAST : st.song_sel - 3'd1;
  assign unit_ms  = st.fast_mode ? {1'b0, base_speed[9:3]} : base_speed[9:2];
  assign note_len = unit_ms * note1;
  assign cd_dbl   = {st.note_countdown, 1'b0};
  assign gap_busy = (st.gap_countdown != 10'd0);

  always_comb begin
    st_nxt = st;
    wr     = '0;
    cd     = st.note_countdown;
    case (beat.func) inside
      FUNC_TICK: begin
        if (gap_busy) begin
          st_nxt.gap_countdown = st.gap_countdown - 10'd1;
          if (st.gap_countdown == 10'd1) begin
            st_nxt.song_sel     = sel_inc;
            st_nxt.note_pointer = '0;
          end
        end else if (st.playing) begin
          if (cd == 16'd0) begin
            if (note0 != END_MARK) begin
              st_nxt.freq_index   = note0;
              st_nxt.note_pointer = st.note_pointer + 10'd2;
              cd                  = note_len;
              st_nxt.tone_running = 1'b1;
            end else begin
              st_nxt.tone_running = 1'b0;
              st_nxt.pin_level    = 1'b1;
              if (song_gap == 10'd0) begin
                st_nxt.song_sel     = sel_inc;
                st_nxt.note_pointer = '0;
              end else begin
                st_nxt.gap_countdown = song_gap;
              end
            end
          end
          if (cd != 16'd0) begin
            cd = cd - 16'd1;
            if (cd == (st.fast_mode ? STOP_LEAD_FAST : STOP_LEAD_NORM)) begin
              st_nxt.tone_running = 1'b0;
              st_nxt.pin_level    = 1'b1;
            end
          end
          st_nxt.note_countdown = cd;
        end
        if (!st_nxt.playing) begin
          st_nxt.tone_running = 1'b0;
          st_nxt.pin_level    = 1'b1;
        end
      end
      FUNC_PLAY_PAUSE, FUNC_SPEED, FUNC_NEXT, FUNC_PREV: begin
        if (!gap_busy) begin
          case (beat.func)
            FUNC_PLAY_PAUSE: begin
              st_nxt.playing = !st.playing;
            end
            FUNC_SPEED: begin
              st_nxt.fast_mode = !st.fast_mode;
              if (!st.fast_mode) begin
                st_nxt.note_countdown = {1'b0, st.note_countdown[15:1]};
              end else begin
                st_nxt.note_countdown = cd_dbl[16] ? 16'hFFFF : cd_dbl[15:0];
              end
            end
            default: begin
              st_nxt.song_sel       = (beat.func == FUNC_NEXT) ? sel_inc : sel_dec;
              st_nxt.note_pointer   = '0;
              st_nxt.note_countdown = '0;
              st_nxt.playing        = 1'b1;
            end
          endcase
          if (!st_nxt.playing) begin
            st_nxt.tone_running = 1'b0;
            st_nxt.pin_level    = 1'b1;
          end
        end
      end
      FUNC_TONE_OVF: begin
        if (st.tone_running && reload_cur != 16'd0) begin
          st_nxt.pin_level = !st.pin_level;
        end
      end
      FUNC_LOAD_NOTE: begin
        wr.note_we = ({1'b0, beat.addr} < NOTE_LIM);
      end
      FUNC_LOAD_START: begin
        wr.start_we = ({1'b0, beat.addr} < SONG_LIM);
      end
      FUNC_LOAD_FREQ: begin
        wr.freq_we = ({1'b0, beat.addr} < FREQ_LIM);
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/buzzer_melody_sequencer.sv @@
// An accepted beat is registered, then executed once the output can take it.
// Throughput: one beat per cycle unless stalled; note memory has two read ports and one
// write port, and note bytes and the reload value are read ahead for the next beat.
// Reset: control state and config registers return to reset values; the note,
// song start and frequency stores are not cleared.
module buzzer_melody_sequencer
  import bms_pkg::*;
#(
  parameter int SONG_COUNT     = 8,
  parameter int NOTE_MEM_DEPTH = 1024,
  parameter int FREQ_ENTRIES   = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_beat_t   in_beat,
  output logic       out_valid,
  input  logic       out_stall,
  output out_beat_t  out_beat,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  localparam int NW = (NOTE_MEM_DEPTH > 1) ? $clog2(NOTE_MEM_DEPTH) : 1;
  localparam int FW = (FREQ_ENTRIES > 1) ? $clog2(FREQ_ENTRIES) : 1;
  localparam int SW = (SONG_COUNT > 1) ? $clog2(SONG_COUNT) : 1;
  localparam logic [8:0] FREQ_LIM = 9'(FREQ_ENTRIES);

  function automatic logic [NW-1:0] note_wrap(input logic [10:0] v);
    logic [15:0] r;
    r = {5'd0, v};
    for (int k = 4; k >= 0; k--) begin
      if (r >= 16'(NOTE_MEM_DEPTH << k)) begin
        r = r - 16'(NOTE_MEM_DEPTH << k);
      end
    end
    return r[NW-1:0];
  endfunction

  logic        e_valid_r;
  in_beat_t    e_beat_r;
  logic        out_valid_r;
  logic        fire;

  logic [9:0]  base_speed_r;
  logic [9:0]  song_gap_r;

  play_state_t st_r;
  play_state_t step_nxt;
  play_state_t st_nxt;
  mem_wr_t     wr;

  logic [9:0]  song_start_r [SONG_COUNT];
  logic [9:0]  start_nxt;
  logic [9:0]  ptr1_nxt;
  logic [NW-1:0] ra0;
  logic [NW-1:0] ra1;
  logic [NW-1:0] note_wa;
  logic        note_we;

  logic [7:0]  note_mem [NOTE_MEM_DEPTH];
  logic [7:0]  note_rd0_r;
  logic [7:0]  note_rd1_r;
  logic        note_byp0_r;
  logic        note_byp1_r;
  logic [7:0]  note_byp_data_r;
  logic [7:0]  note0;
  logic [7:0]  note1;

  logic [15:0] freq_mem [FREQ_ENTRIES];
  logic [FW-1:0] freq_ra;
  logic [FW-1:0] freq_wa;
  logic        freq_we;
  logic [15:0] freq_rd_r;
  logic        freq_byp_r;
  logic [15:0] freq_byp_data_r;
  logic        freq_ok_r;
  logic [15:0] reload_cur;

  assign fire      = e_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = e_valid_r && !fire;
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        e_valid_r <= 1'b1;
      end else if (fire) begin
        e_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      e_beat_r <= in_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_speed_r <= BASE_SPEED_RST;
      song_gap_r   <= SONG_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASE_SPEED: base_speed_r <= cfg_data;
        CFG_SONG_GAP:   song_gap_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bms_step #(
    .SONG_COUNT    (SONG_COUNT),
    .NOTE_MEM_DEPTH(NOTE_MEM_DEPTH),
    .FREQ_ENTRIES  (FREQ_ENTRIES)
  ) u_step (
    .st        (st_r),
    .beat      (e_beat_r),
    .base_speed(base_speed_r),
    .song_gap  (song_gap_r),
    .note0     (note0),
    .note1     (note1),
    .reload_cur(reload_cur),
    .st_nxt    (step_nxt),
    .wr        (wr)
  );

  assign st_nxt = fire ? step_nxt : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RST;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && wr.start_we) begin
      song_start_r[e_beat_r.addr[SW-1:0]] <= e_beat_r.data[9:0];
    end
  end

  // read ahead at the state the next beat will see, forwarding this cycle's writes
  assign start_nxt = (fire && wr.start_we && e_beat_r.addr[SW-1:0] == st_nxt.song_sel[SW-1:0])
                     ? e_beat_r.data[9:0] : song_start_r[st_nxt.song_sel[SW-1:0]];
  assign ptr1_nxt  = st_nxt.note_pointer + 10'd1;
  assign ra0       = note_wrap({1'b0, start_nxt} + {1'b0, st_nxt.note_pointer});
  assign ra1       = note_wrap({1'b0, start_nxt} + {1'b0, ptr1_nxt});
  assign note_wa   = e_beat_r.addr[NW-1:0];
  assign note_we   = fire && wr.note_we;

  always_ff @(posedge clk) begin
    if (note_we) begin
      note_mem[note_wa] <= e_beat_r.data[7:0];
    end
    note_rd0_r      <= note_mem[ra0];
    note_rd1_r      <= note_mem[ra1];
    note_byp_data_r <= e_beat_r.data[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_byp0_r <= 1'b0;
      note_byp1_r <= 1'b0;
    end else begin
      note_byp0_r <= note_we && (note_wa == ra0);
      note_byp1_r <= note_we && (note_wa == ra1);
    end
  end

  assign note0 = note_byp0_r ? note_byp_data_r : note_rd0_r;
  assign note1 = note_byp1_r ? note_byp_data_r : note_rd1_r;

  assign freq_ra = st_nxt.freq_index[FW-1:0];
  assign freq_wa = e_beat_r.addr[FW-1:0];
  assign freq_we = fire && wr.freq_we;

  always_ff @(posedge clk) begin
    if (freq_we) begin
      freq_mem[freq_wa] <= e_beat_r.data;
    end
    freq_rd_r       <= freq_mem[freq_ra];
    freq_byp_data_r <= e_beat_r.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_byp_r <= 1'b0;
      freq_ok_r  <= 1'b1;
    end else begin
      freq_byp_r <= freq_we && (freq_wa == freq_ra);
      freq_ok_r  <= ({1'b0, st_nxt.freq_index} < FREQ_LIM);
    end
  end

  assign reload_cur = !freq_ok_r ? 16'd0 : (freq_byp_r ? freq_byp_data_r : freq_rd_r);

  assign out_beat = '{
    tone_on:      st_r.tone_running,
    buzzer:       st_r.pin_level,
    reload_value: reload_cur,
    song_number:  st_r.song_sel,
    is_playing:   st_r.playing,
    double_speed: st_r.fast_mode
  };

  a_gap_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.gap_countdown != 10'd0) |-> (!st_r.tone_running && st_r.pin_level))
    else $error("tone active during song gap");

  a_tone_needs_play: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.tone_running |-> st_r.playing)
    else $error("tone running while paused");

  a_pin_low_needs_tone: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.pin_level |-> st_r.tone_running)
    else $error("buzzer driven low with tone stopped");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> e_valid_r)
    else $error("accepted beat lost before execution");

endmodule

@@ verif/buzzer_melody_sequencer_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for buzzer_melody_sequencer: directed events, then random
// phases of song playback under several register settings. Depends on bms_pkg and the DUT.
module buzzer_melody_sequencer_tb;
  import bms_pkg::*;

  localparam int SONGS       = 8;
  localparam int NOTE_DEPTH  = 1024;
  localparam int PITCHES     = 256;
  localparam int FUNC_CODES  = 16;
  localparam int QUIET       = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1_000_000;

  class melody_scoreboard;
    bit [9:0]  tempo;
    bit [9:0]  gap_ms;
    bit        running;
    bit        fast;
    bit [2:0]  song;
    bit [9:0]  cursor;
    bit [15:0] remaining;
    bit [9:0]  gap_left;
    bit [7:0]  pitch;
    bit        tone;
    bit        pin;
    bit [7:0]  score [NOTE_DEPTH];
    bit        score_set [NOTE_DEPTH];
    bit [9:0]  song_base [SONGS];
    bit        base_set [SONGS];
    bit [15:0] pitch_reload [PITCHES];
    bit        reload_set [PITCHES];
    out_beat_t due [$];
    int        errors;

    function new();
      tempo  = BASE_SPEED_RST;
      gap_ms = SONG_GAP_RST;
      pin    = 1'b1;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void set_reg(logic [1:0] idx, logic [9:0] val);
      if (idx == CFG_BASE_SPEED) tempo = val;
      else if (idx == CFG_SONG_GAP) gap_ms = val;
    endfunction

    function bit [9:0] score_addr(bit [9:0] off);
      return 10'(song_base[song] + off);
    endfunction

    function void mute();
      tone = 1'b0;
      pin  = 1'b1;
    endfunction

    function void next_song();
      song   = 3'((int'(song) + 1) % SONGS);
      cursor = '0;
    endfunction

    function void tick();
      bit [7:0] note_pitch;
      bit [7:0] note_len;
      if (gap_left != 0) begin
        gap_left--;
        if (gap_left == 0) next_song();
        return;
      end
      if (!running) return;
      if (remaining == 0) begin
        note_pitch = score[score_addr(cursor)];
        if (note_pitch != END_MARK) begin
          pitch = note_pitch;
          cursor++;
          note_len = score[score_addr(cursor)];
          cursor++;
          remaining = 16'((int'(tempo) / (fast ? 8 : 4)) * int'(note_len));
          tone = 1'b1;
        end else begin
          mute();
          if (gap_ms == 0) next_song();
          else gap_left = gap_ms;
        end
      end
      if (remaining > 0) begin
        remaining--;
        if (remaining == (fast ? STOP_LEAD_FAST : STOP_LEAD_NORM)) mute();
      end
    endfunction

    function void note_event(in_beat_t b);
      bit        key;
      out_beat_t o;
      key = (b.func >= FUNC_PLAY_PAUSE) && (b.func <= FUNC_PREV);
      if (!(key && gap_left != 0)) begin
        case (b.func)
          FUNC_TICK: tick();
          FUNC_PLAY_PAUSE: running = !running;
          FUNC_SPEED: begin
            fast = !fast;
            if (fast) remaining = remaining >> 1;
            else remaining = (remaining > 16'h7FFF) ? 16'hFFFF : remaining << 1;
          end
          FUNC_NEXT, FUNC_PREV: begin
            if (b.func == FUNC_NEXT) song = 3'((int'(song) + 1) % SONGS);
            else song = 3'((int'(song) + SONGS - 1) % SONGS);
            cursor    = '0;
            remaining = '0;
            running   = 1'b1;
          end
          FUNC_TONE_OVF: if (tone && pitch_reload[pitch] != 0) pin = !pin;
          FUNC_LOAD_NOTE: begin
            score[b.addr]     = b.data[7:0];
            score_set[b.addr] = 1'b1;
          end
          FUNC_LOAD_START: if (b.addr < SONGS) begin
            song_base[b.addr[2:0]] = b.data[9:0];
            base_set[b.addr[2:0]]  = 1'b1;
          end
          FUNC_LOAD_FREQ: if (b.addr < PITCHES) begin
            pitch_reload[b.addr[7:0]] = b.data;
            reload_set[b.addr[7:0]]   = 1'b1;
          end
          default: ;
        endcase
        if ((b.func == FUNC_TICK || key) && !running) mute();
      end
      o.tone_on      = tone;
      o.buzzer       = pin;
      o.reload_value = pitch_reload[pitch];
      o.song_number  = song;
      o.is_playing   = running;
      o.double_speed = fast;
      due.push_back(o);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (due.size() == 0) begin
        $display("%0t: beat %h expected none actual arrived", $time, got);
        errors++;
        return;
      end
      want = due.pop_front();
      compare("tone_on", want.tone_on, got.tone_on);
      compare("buzzer", want.buzzer, got.buzzer);
      compare("reload_value", want.reload_value, got.reload_value);
      compare("song_number", want.song_number, got.song_number);
      compare("is_playing", want.is_playing, got.is_playing);
      compare("double_speed", want.double_speed, got.double_speed);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_beat_t   in_beat = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_beat_t  out_beat;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;

  int send_idle    = 0;
  int stall_pct    = 0;
  int note_len_max = 3;
  bit hold_req     = 1'b0;
  int cycle_count  = 0;

  melody_scoreboard melody = new();

  buzzer_melody_sequencer #(
    .SONG_COUNT    (SONGS),
    .NOTE_MEM_DEPTH(NOTE_DEPTH),
    .FREQ_ENTRIES  (PITCHES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) melody.check_result(out_beat);
  end

  // hold off for a long stretch on request, otherwise stall at random
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic in_beat_t beat_of(logic [3:0] func, logic [9:0] addr, logic [15:0] data);
    in_beat_t b;
    b.func = func;
    b.addr = addr;
    b.data = data;
    return b;
  endfunction

  task automatic push_event(in_beat_t b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall);
    melody.note_event(b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (melody.pending() != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    melody.set_reg(idx, val);
  endtask

  // load whatever the coming note fetch would read before it is written
  task automatic prepare_fetch();
    logic [9:0] at;
    logic [7:0] note_pitch;
    if (melody.gap_left != 0 || !melody.running || melody.remaining != 0) return;
    if (!melody.base_set[melody.song])
      push_event(beat_of(FUNC_LOAD_START, 10'(melody.song), 16'($urandom)));
    at = melody.score_addr(melody.cursor);
    if (!melody.score_set[at]) begin
      if ($urandom_range(5) == 0) note_pitch = END_MARK;
      else if ($urandom_range(4) != 0) note_pitch = 8'($urandom_range(31));
      else note_pitch = 8'($urandom_range(254));
      push_event(beat_of(FUNC_LOAD_NOTE, at, {8'($urandom), note_pitch}));
    end
    note_pitch = melody.score[at];
    if (note_pitch == END_MARK) return;
    if (!melody.score_set[10'(at + 10'd1)])
      push_event(beat_of(FUNC_LOAD_NOTE, 10'(at + 10'd1),
                         {8'($urandom), 8'($urandom_range(note_len_max))}));
    if (!melody.reload_set[note_pitch])
      push_event(beat_of(FUNC_LOAD_FREQ, 10'(note_pitch),
                         ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom)));
  endtask

  task automatic tick_event();
    prepare_fetch();
    push_event(beat_of(FUNC_TICK, 10'($urandom), 16'($urandom)));
  endtask

  task automatic random_event();
    int       roll;
    in_beat_t b;
    roll   = $urandom_range(99);
    b.addr = 10'($urandom);
    b.data = 16'($urandom);
    if (roll < 50) b.func = FUNC_TICK;
    else if (roll < 53) b.func = FUNC_PLAY_PAUSE;
    else if (roll < 58) b.func = FUNC_SPEED;
    else if (roll < 62) b.func = FUNC_NEXT;
    else if (roll < 65) b.func = FUNC_PREV;
    else if (roll < 80) b.func = FUNC_TONE_OVF;
    else if (roll < 88) b.func = FUNC_LOAD_NOTE;
    else if (roll < 92) b.func = FUNC_LOAD_START;
    else if (roll < 97) b.func = FUNC_LOAD_FREQ;
    else b.func = 4'($urandom_range(FUNC_CODES - 1, FUNC_LOAD_FREQ + 1));
    if (!melody.running && melody.gap_left == 0 && $urandom_range(3) == 0)
      b.func = FUNC_PLAY_PAUSE;
    case (b.func)
      FUNC_LOAD_NOTE: if ($urandom_range(1) == 0) b.data[7:0] = 8'($urandom_range(note_len_max));
      FUNC_LOAD_START: if ($urandom_range(9) < 7) b.addr = 10'($urandom_range(SONGS - 1));
      FUNC_LOAD_FREQ: begin
        if ($urandom_range(9) < 7) b.addr = 10'($urandom_range(PITCHES - 1));
        if ($urandom_range(9) == 0) b.data = '0;
      end
      default: ;
    endcase
    if (b.func == FUNC_TICK) tick_event();
    else push_event(b);
  endtask

  task automatic run_phase(logic [9:0] speed, logic [9:0] gap, int idle, int stall,
                           int len_max, int count, bit squeeze);
    write_reg(CFG_BASE_SPEED, speed);
    write_reg(CFG_SONG_GAP, gap);
    send_idle    = idle;
    stall_pct    = stall;
    note_len_max = len_max;
    if (squeeze) hold_req = 1'b1;
    repeat (count) random_event();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_event(beat_of(FUNC_LOAD_FREQ, 10'd0, 16'hFFFF));
    push_event(beat_of(FUNC_LOAD_FREQ, 10'd1023, 16'h1234));
    push_event(beat_of(FUNC_LOAD_FREQ, 10'd255, 16'h0000));
    push_event(beat_of(FUNC_LOAD_START, 10'd0, 16'hFFFF));
    push_event(beat_of(FUNC_LOAD_START, 10'd1023, 16'h0000));
    push_event(beat_of(FUNC_LOAD_NOTE, 10'd1023, 16'hA500));
    push_event(beat_of(FUNC_LOAD_NOTE, 10'd0, 16'h00FF));
    push_event(beat_of(FUNC_LOAD_NOTE, 10'd1, {8'h5A, END_MARK}));
    push_event(beat_of(FUNC_TONE_OVF, 10'd0, 16'd0));
    push_event(beat_of(4'(FUNC_LOAD_FREQ + 1), 10'h3FF, 16'hFFFF));
    push_event(beat_of(4'(FUNC_CODES - 1), 10'h3FF, 16'hFFFF));
    tick_event();
    push_event(beat_of(FUNC_PLAY_PAUSE, 10'd0, 16'd0));
    tick_event();
    push_event(beat_of(FUNC_TONE_OVF, 10'd0, 16'd0));
    push_event(beat_of(FUNC_SPEED, 10'd0, 16'd0));
    push_event(beat_of(FUNC_TONE_OVF, 10'd0, 16'd0));
    push_event(beat_of(FUNC_SPEED, 10'd0, 16'd0));
    push_event(beat_of(FUNC_PLAY_PAUSE, 10'd0, 16'd0));
    tick_event();
    push_event(beat_of(FUNC_PLAY_PAUSE, 10'd0, 16'd0));
    push_event(beat_of(FUNC_PREV, 10'd0, 16'd0));
    push_event(beat_of(FUNC_NEXT, 10'd0, 16'd0));
    push_event(beat_of(FUNC_NEXT, 10'd0, 16'd0));
    tick_event();

    run_phase(10'd1, 10'd0, 0, 0, 3, 150, 1'b0);
    run_phase(10'd40, 10'd2, 88, 0, 4, 150, 1'b0);
    run_phase(10'd12, 10'd5, 0, 88, 6, 150, 1'b0);
    run_phase(10'd200, 10'd1, 24, 24, 2, 150, 1'b1);
    run_phase(10'd1000, 10'd1023, 0, 0, 2, 100, 1'b0);
    drain();
    repeat (60) random_event();

    drain();
    if (melody.errors == 0 && melody.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ buzzer_melody_sequencer.f @@
hdl/bms_pkg.sv
hdl/bms_step.sv
hdl/buzzer_melody_sequencer.sv
verif/buzzer_melody_sequencer_tb.sv
